// ===== src/csa_pkg.sv =====
// Shared types and constants of the cosine similarity accumulator.
package csa_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ACC_W      = 48;
   localparam int HALF_W     = ACC_W / 2;
   localparam int PROD_W     = 2 * ACC_W;
   localparam int QUOT_W     = 32;
   localparam int ROOT_W     = QUOT_W / 2;
   localparam int SQ_REM_W   = ROOT_W + 2;
   localparam int MUL_SEL_W  = 3;
   localparam int STEP_W     = 5;
   localparam int MUL_STEPS  = 8;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int SQRT_STEPS = ROOT_W;

   localparam logic signed [SAMPLE_W-1:0] SIM_MAX = 16'sh7FFF;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] element_a;
      logic signed [SAMPLE_W-1:0] element_b;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] similarity;
      logic                       zero_norm;
      logic                       too_long;
   } rsp_type;

   typedef struct packed {
      logic                 take;
      logic                 capture;
      logic                 mul_en;
      logic [MUL_SEL_W-1:0] mul_sel;
      logic                 div_init;
      logic                 sat;
      logic                 div_step;
      logic                 sqrt_step;
      logic                 finish;
   } cmd_type;

   typedef struct packed {
      logic zero_norm;
      logic ovf;
   } status_type;

endpackage

// ===== src/csa_datapath.sv =====
// Accumulators, shared multiplier, divider and square root of the similarity unit.
module csa_datapath #(
   parameter int MAX_LEN     = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  csa_pkg::req_type  req_data,
   input  csa_pkg::cmd_type  cmd,
   output csa_pkg::status_type status,
   output logic              rsp_valid,
   output csa_pkg::rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(MAX_LEN + 2);
   localparam int EXT_W = csa_pkg::SAMPLE_W + SAMPLE_BITS;

   // Input stage.
   logic [EXT_W-1:0]              ext_a;
   logic [EXT_W-1:0]              ext_b;
   logic signed [SAMPLE_BITS-1:0] sa;
   logic signed [SAMPLE_BITS-1:0] sb;
   logic signed [csa_pkg::ACC_W-1:0] pdot_in, pa_in, pb_in;
   logic signed [csa_pkg::ACC_W-1:0] pdot_ff, pa_ff, pb_ff;
   logic                          add_en_ff;
   logic [CNT_W-1:0]              count_ff;

   // Accumulators.
   logic [csa_pkg::ACC_W-1:0] dot_ff, norm_a_ff, norm_b_ff;

   // Finishing datapath.
   logic                        neg_ff, zero_ff, long_ff;
   logic [csa_pkg::ACC_W-1:0]   dmag_in, dmag_ff;
   logic [csa_pkg::HALF_W-1:0]  x_part, y_part;
   logic [csa_pkg::ACC_W-1:0]   opx, opy;
   logic [csa_pkg::ACC_W-1:0]   pp_ff;
   logic                        pp_valid_ff;
   logic [csa_pkg::MUL_SEL_W-1:0] pp_sel_ff;
   logic [csa_pkg::PROD_W-1:0]  pp_shift;
   logic [csa_pkg::PROD_W-1:0]  prod_ff;
   logic [csa_pkg::PROD_W-1:0]  rem_ff;
   logic [csa_pkg::PROD_W:0]    rem_dbl;
   logic                        div_ge;
   logic [csa_pkg::QUOT_W-1:0]  quot_ff;
   logic [csa_pkg::SQ_REM_W-1:0] sq_rem_ff;
   logic [csa_pkg::ROOT_W-1:0]  root_ff;
   logic [csa_pkg::SQ_REM_W+1:0] sq_t;
   logic [csa_pkg::SQ_REM_W+1:0] sq_trial;
   logic                        sq_ge;
   logic [csa_pkg::ROOT_W:0]    k_sum;
   logic [csa_pkg::ROOT_W-1:0]  k_mag;
   logic signed [csa_pkg::SAMPLE_W-1:0] sim;
   logic                        rsp_valid_ff;
   csa_pkg::rsp_type            rsp_ff;

   // Only the low SAMPLE_BITS bits of an element count; wider samples zero-extend.
   assign ext_a   = {{SAMPLE_BITS{1'b0}}, req_data.element_a};
   assign ext_b   = {{SAMPLE_BITS{1'b0}}, req_data.element_b};
   assign sa      = ext_a[SAMPLE_BITS-1:0];
   assign sb      = ext_b[SAMPLE_BITS-1:0];
   assign pdot_in = csa_pkg::ACC_W'(sa * sb);
   assign pa_in   = csa_pkg::ACC_W'(sa * sa);
   assign pb_in   = csa_pkg::ACC_W'(sb * sb);

   always_ff @(posedge clock) begin
      pdot_ff <= pdot_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_en_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         add_en_ff <= cmd.take && (count_ff < CNT_W'(MAX_LEN));
         if (cmd.finish) begin
            count_ff <= '0;
         end else if (cmd.take) begin
            if (count_ff < CNT_W'(MAX_LEN)) begin
               count_ff <= count_ff + CNT_W'(1);
            end else begin
               count_ff <= CNT_W'(MAX_LEN + 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff    <= '0;
         norm_a_ff <= '0;
         norm_b_ff <= '0;
      end else if (cmd.finish) begin
         dot_ff    <= '0;
         norm_a_ff <= '0;
         norm_b_ff <= '0;
      end else if (add_en_ff) begin
         dot_ff    <= dot_ff + pdot_ff;
         norm_a_ff <= norm_a_ff + pa_ff;
         norm_b_ff <= norm_b_ff + pb_ff;
      end
   end

   assign status.zero_norm = (norm_a_ff == '0) || (norm_b_ff == '0);
   assign status.ovf       = (rem_ff >= prod_ff);

   assign dmag_in = dot_ff[csa_pkg::ACC_W-1] ? (csa_pkg::ACC_W'(0) - dot_ff) : dot_ff;

   // Steps 0 to 3 form norm_a * norm_b, steps 4 to 7 form dmag * dmag,
   // each from four 24 by 24 partial products.
   always_comb begin
      opx = cmd.mul_sel[2] ? dmag_ff : norm_a_ff;
      opy = cmd.mul_sel[2] ? dmag_ff : norm_b_ff;
   end

   assign x_part = cmd.mul_sel[1] ? opx[csa_pkg::ACC_W-1:csa_pkg::HALF_W]
                                  : opx[csa_pkg::HALF_W-1:0];
   assign y_part = cmd.mul_sel[0] ? opy[csa_pkg::ACC_W-1:csa_pkg::HALF_W]
                                  : opy[csa_pkg::HALF_W-1:0];

   always_comb begin
      case (pp_sel_ff[1:0]) inside
         2'b00:        pp_shift = csa_pkg::PROD_W'(pp_ff);
         2'b01, 2'b10: pp_shift = csa_pkg::PROD_W'(pp_ff) << csa_pkg::HALF_W;
         default:      pp_shift = csa_pkg::PROD_W'(pp_ff) << csa_pkg::ACC_W;
      endcase
   end

   always_ff @(posedge clock) begin
      pp_ff     <= x_part * y_part;
      pp_sel_ff <= cmd.mul_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff <= 1'b0;
      end else begin
         pp_valid_ff <= cmd.mul_en;
      end
   end

   // Restoring division: the remainder starts as dot squared and zeros shift in.
   assign rem_dbl = {rem_ff, 1'b0};
   assign div_ge  = (rem_dbl >= {1'b0, prod_ff});

   // Digit-by-digit square root of the quotient, two bits per step.
   assign sq_t     = {sq_rem_ff, quot_ff[csa_pkg::QUOT_W-1 -: 2]};
   assign sq_trial = (csa_pkg::SQ_REM_W + 2)'({root_ff, 2'b01});
   assign sq_ge    = (sq_t >= sq_trial);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         neg_ff  <= dot_ff[csa_pkg::ACC_W-1];
         dmag_ff <= dmag_in;
         zero_ff <= status.zero_norm;
         long_ff <= (count_ff > CNT_W'(MAX_LEN));
         prod_ff <= '0;
         rem_ff  <= '0;
      end else if (pp_valid_ff) begin
         if (pp_sel_ff[2]) begin
            rem_ff <= rem_ff + pp_shift;
         end else begin
            prod_ff <= prod_ff + pp_shift;
         end
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= csa_pkg::PROD_W'(rem_dbl - {1'b0, prod_ff});
         end else begin
            rem_ff <= csa_pkg::PROD_W'(rem_dbl);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sat) begin
         quot_ff   <= '1;
         sq_rem_ff <= '0;
         root_ff   <= '0;
      end else if (cmd.div_init) begin
         quot_ff   <= '0;
         sq_rem_ff <= '0;
         root_ff   <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[csa_pkg::QUOT_W-2:0], div_ge};
      end else if (cmd.sqrt_step) begin
         quot_ff   <= {quot_ff[csa_pkg::QUOT_W-3:0], 2'b00};
         sq_rem_ff <= sq_ge ? csa_pkg::SQ_REM_W'(sq_t - sq_trial)
                            : csa_pkg::SQ_REM_W'(sq_t);
         root_ff   <= {root_ff[csa_pkg::ROOT_W-2:0], sq_ge};
      end
   end

   // The largest odd m with m*m <= quotient gives the magnitude (m + 1) / 2.
   assign k_sum = (csa_pkg::ROOT_W + 1)'(root_ff) + (csa_pkg::ROOT_W + 1)'(1);
   assign k_mag = k_sum[csa_pkg::ROOT_W:1];

   always_comb begin
      if (zero_ff) begin
         sim = '0;
      end else if (neg_ff) begin
         sim = csa_pkg::SAMPLE_W'(0) - k_mag;
      end else if (k_mag[csa_pkg::ROOT_W-1]) begin
         sim = csa_pkg::SIM_MAX;
      end else begin
         sim = k_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.similarity <= sim;
         rsp_ff.zero_norm  <= zero_ff;
         rsp_ff.too_long   <= long_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/csa_controller.sv =====
// Sequencing state machine of the cosine similarity accumulator.
module csa_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                last,
   input  csa_pkg::status_type status,
   output logic                busy,
   output csa_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DRAIN_IN  = 4'd1;
   localparam logic [3:0] S_CAPTURE   = 4'd2;
   localparam logic [3:0] S_MUL       = 4'd3;
   localparam logic [3:0] S_MUL_DRAIN = 4'd4;
   localparam logic [3:0] S_CMP       = 4'd5;
   localparam logic [3:0] S_DIV       = 4'd6;
   localparam logic [3:0] S_SQRT      = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0]                   state_ff, state_in;
   logic [csa_pkg::STEP_W-1:0]   step_ff, step_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = start;
            if (start && last) begin
               state_in = S_DRAIN_IN;
            end
         end
         S_DRAIN_IN: begin
            state_in = S_CAPTURE;
         end
         S_CAPTURE: begin
            cmd.capture = 1'b1;
            step_in     = '0;
            state_in    = status.zero_norm ? S_DONE : S_MUL;
         end
         S_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = step_ff[csa_pkg::MUL_SEL_W-1:0];
            if (step_ff == csa_pkg::STEP_W'(csa_pkg::MUL_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_MUL_DRAIN;
            end else begin
               step_in = step_ff + csa_pkg::STEP_W'(1);
            end
         end
         S_MUL_DRAIN: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            // A quotient of 2^32 or more can only give full scale.
            if (status.ovf) begin
               cmd.sat  = 1'b1;
               state_in = S_SQRT;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
            step_in = '0;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == csa_pkg::STEP_W'(csa_pkg::DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_SQRT;
            end else begin
               step_in = step_ff + csa_pkg::STEP_W'(1);
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == csa_pkg::STEP_W'(csa_pkg::SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_DONE;
            end else begin
               step_in = step_ff + csa_pkg::STEP_W'(1);
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== src/cosine_similarity_accumulator_unit.sv =====
// Top level of the streaming cosine similarity unit.
// Element pairs transfer one per clock while busy is low. After the pair marked last,
// busy stays high while the sequencer drains the input stage, captures the sums,
// forms eight partial products on one 24 by 24 multiplier, runs a 32-step restoring
// divider and a 16-step square root (no division when the quotient saturates at full
// scale, none of these when a norm is zero); the result strobe rsp_valid is high for
// one cycle, the first one in which busy is low again. The receiver cannot stall a
// result, so it must take rsp_data whenever rsp_valid is high.
module cosine_similarity_accumulator_unit #(
   parameter int MAX_LEN     = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  csa_pkg::req_type req_data,
   output logic             rsp_valid,
   output csa_pkg::rsp_type rsp_data
);

   csa_pkg::cmd_type    cmd;
   csa_pkg::status_type status;

   csa_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .last   (req_data.last),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   csa_datapath #(
      .MAX_LEN     (MAX_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
